[rtl/mlps_pkg.sv]
`timescale 1ns / 1ps

package mlps_pkg;

    localparam int DEF_MAX_LEVELS = 8;

    localparam logic [31:0] INV_LN_Q32    = 32'd952350469;
    localparam logic [31:0] OCC_RATIO_Q32 = 32'd4247722655;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SCALE_W,
        ST_SQ,
        ST_SQ_W,
        ST_DIV,
        ST_OCC,
        ST_OCC_W,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } t_div_stat;

endpackage

[rtl/mlps_if.sv]
`timescale 1ns / 1ps

interface mlps_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] item_count;
    logic [3:0]  level_count;

    modport source (output valid, output item_count, output level_count, input ready);
    modport sink   (input valid, input item_count, input level_count, output ready);
endinterface

interface mlps_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] level_size;
    logic [31:0] total_size;
    logic        overflow_error;
    logic        last;

    modport source (output valid, output level_size, output total_size,
                    output overflow_error, output last, input ready);
    modport sink   (input valid, input level_size, input total_size,
                    input overflow_error, input last, output ready);
endinterface

[rtl/mlps_mul.sv]
`timescale 1ns / 1ps

module mlps_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[rtl/mlps_div.sv]
`timescale 1ns / 1ps

module mlps_div
    import mlps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_cmd    i_cmd,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output t_div_stat   o_stat
);

    logic [32:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dvs, n_dvs;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] shifted;

    // one remainder bit per cycle, restoring
    always_comb begin
        shifted = {r_rem[31:0], r_quo[31]};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_cmd.start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = shifted - {1'b0, r_dvs};
            end else begin
                n_rem = shifted;
            end
            n_quo = {r_quo[30:0], 1'b0};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == 33'd0);

endmodule

[rtl/multi_level_prime_size_generator.sv]
`timescale 1ns / 1ps
// channel   dir  word                                              handshake
// i_in      in   item_count[31:0], level_count[3:0]                valid/ready
// o_out     out  level_size[31:0], total_size[31:0], overflow_error, last
//                                                                  valid/ready
// one request at a time; i_in.ready is high only when idle
// per level: a scale multiply, an occupancy multiply and an output state, plus for a
// candidate above 2 a closing d*d test, plus per odd divisor tried a d*d test on the shared
// multiplier and a pass through the bit-serial remainder unit
// synchronous active-low reset returns the sequencer to idle, nothing to clear
// a waiting result holds the sequencer until o_out.ready takes it

module multi_level_prime_size_generator
    import mlps_pkg::*;
#(
    parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlps_in_if.sink     i_in,
    mlps_out_if.source  o_out
);

    localparam int LVL_W = $clog2(MAX_LEVELS + 1);

    t_state r_state, n_state;

    logic [31:0]      r_rem, n_rem;
    logic [LVL_W-1:0] r_lvls, n_lvls;
    logic [LVL_W-1:0] r_idx, n_idx;
    logic [31:0]      r_total, n_total;
    logic [31:0]      r_cand, n_cand;
    logic [31:0]      r_d, n_d;
    logic [31:0]      r_out_size, n_out_size;
    logic [31:0]      r_out_total, n_out_total;
    logic             r_out_err, n_out_err;
    logic             r_out_last, n_out_last;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    t_div_cmd    div_cmd;
    t_div_stat   div_stat;

    logic [31:0]      scaled;
    logic [31:0]      occ;
    logic             sq_over;
    logic             err;
    logic             is_last;
    logic [LVL_W-1:0] lvl_in;

    assign scaled  = prod[63:32];
    assign occ     = prod[63:32];
    assign sq_over = prod > {32'd0, r_cand};
    assign err     = r_rem < occ;
    assign is_last = err || (LVL_W'(r_idx + 1'b1) == r_lvls);
    assign lvl_in  = (32'(i_in.level_count) > 32'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS)
                                                              : LVL_W'(i_in.level_count);

    mlps_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    mlps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .i_dividend (r_cand),
        .i_divisor  (r_d),
        .o_stat     (div_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid && (i_in.level_count != 4'd0)) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE:   n_state = ST_SCALE_W;
            ST_SCALE_W: n_state = (scaled <= 32'd2) ? ST_OCC : ST_SQ;
            ST_SQ:      n_state = ST_SQ_W;
            ST_SQ_W:    n_state = sq_over ? ST_OCC : ST_DIV;
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_SQ;
                end
            end
            ST_OCC:   n_state = ST_OCC_W;
            ST_OCC_W: n_state = ST_OUT;
            ST_OUT: begin
                if (o_out.ready) begin
                    n_state = r_out_last ? ST_IDLE : ST_SCALE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_in.ready    = 1'b0;
        o_out.valid   = 1'b0;
        div_cmd.start = 1'b0;
        mul_a         = r_rem;
        mul_b         = INV_LN_Q32;
        case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            ST_SQ: begin
                mul_a = r_d;
                mul_b = r_d;
            end
            ST_SQ_W: div_cmd.start = !sq_over;
            ST_OCC: begin
                mul_a = r_cand;
                mul_b = OCC_RATIO_Q32;
            end
            ST_OUT: o_out.valid = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_rem       = r_rem;
        n_lvls      = r_lvls;
        n_idx       = r_idx;
        n_total     = r_total;
        n_cand      = r_cand;
        n_d         = r_d;
        n_out_size  = r_out_size;
        n_out_total = r_out_total;
        n_out_err   = r_out_err;
        n_out_last  = r_out_last;
        case (r_state)
            ST_IDLE: begin
                n_rem   = i_in.item_count;
                n_lvls  = lvl_in;
                n_idx   = '0;
                n_total = '0;
            end
            ST_SCALE_W: begin
                if (scaled <= 32'd2) begin
                    n_cand = 32'd2;
                end else begin
                    n_cand = scaled | 32'd1;
                    n_d    = 32'd3;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (div_stat.rem_zero) begin
                        n_cand = r_cand + 32'd2;
                        n_d    = 32'd3;
                    end else begin
                        n_d = r_d + 32'd2;
                    end
                end
            end
            ST_OCC_W: begin
                n_total     = r_total + r_cand;
                n_out_size  = r_cand;
                n_out_total = r_total + r_cand;
                n_out_err   = err;
                n_out_last  = is_last;
                n_rem       = r_rem - occ;
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_idx = LVL_W'(r_idx + 1'b1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_lvls      <= n_lvls;
        r_idx       <= n_idx;
        r_total     <= n_total;
        r_cand      <= n_cand;
        r_d         <= n_d;
        r_out_size  <= n_out_size;
        r_out_total <= n_out_total;
        r_out_err   <= n_out_err;
        r_out_last  <= n_out_last;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_out.level_size     = r_out_size;
    assign o_out.total_size     = r_out_total;
    assign o_out.overflow_error = r_out_err;
    assign o_out.last           = r_out_last;

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a result is pending");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_cmd.start |-> !div_stat.busy)
        else $error("remainder unit started while busy");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow_error) |-> o_out.last)
        else $error("flagged level not marked last");

    a_cand_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> r_cand[0])
        else $error("trial division on an even candidate");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !div_stat.done) |-> div_stat.busy)
        else $error("waiting on an idle remainder unit");

endmodule

[tb/multi_level_prime_size_generator_tb.sv]
`timescale 1ns / 1ps

module multi_level_prime_size_generator_tb
    import mlps_pkg::*;
();

    localparam logic [31:0] INV_SCALE_Q32 = 32'd952350469;
    localparam logic [31:0] FILL_RATIO_Q32 = 32'd4247722655;
    localparam int IDLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [31:0] level_size;
        logic [31:0] total_size;
        logic        overflow_error;
        logic        last;
    } t_level_word;

    logic i_clk;
    logic i_rst_n;

    mlps_in_if  req_if ();
    mlps_out_if size_if ();

    t_level_word pending_levels[$];
    int          mismatch_count;
    int          idle_cycles = 0;
    bit          burst_in;
    bit          burst_out;

    multi_level_prime_size_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (size_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_prime(logic [31:0] v);
        logic [63:0] d;
        if (v < 32'd2) return 1'b0;
        if (v == 32'd2) return 1'b1;
        if (!v[0]) return 1'b0;
        for (d = 64'd3; d * d <= 64'(v); d += 64'd2) begin
            if (v % d[31:0] == 32'd0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] prime_from(logic [31:0] v);
        logic [31:0] c;
        if (v <= 32'd2) return 32'd2;
        c = v | 32'd1;
        while (!is_prime(c)) c += 32'd2;
        return c;
    endfunction

    task automatic predict_level_sizes(logic [31:0] count, logic [3:0] levels_req);
        logic [31:0] remaining;
        logic [31:0] scaled;
        logic [31:0] occupied;
        logic [31:0] running;
        int          levels;
        t_level_word w;
        remaining = count;
        running   = 32'd0;
        levels    = (levels_req > DEF_MAX_LEVELS) ? DEF_MAX_LEVELS : int'(levels_req);
        for (int i = 0; i < levels; i++) begin
            scaled   = 32'((64'(remaining) * 64'(INV_SCALE_Q32)) >> 32);
            w.level_size = prime_from(scaled);
            occupied = 32'((64'(w.level_size) * 64'(FILL_RATIO_Q32)) >> 32);
            running += w.level_size;
            w.total_size     = running;
            w.overflow_error = (remaining < occupied);
            w.last           = w.overflow_error || (i + 1 == levels);
            pending_levels = {pending_levels, w};
            if (w.overflow_error) break;
            remaining -= occupied;
        end
    endtask

    task automatic send_request(logic [31:0] count, logic [3:0] levels_req);
        int gap;
        gap = burst_in ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.item_count  <= count;
        req_if.level_count <= levels_req;
        req_if.valid       <= 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        predict_level_sizes(count, levels_req);
    endtask

    task automatic check_level_word(t_level_word got);
        t_level_word want;
        if (pending_levels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected word: size %0d total %0d err %0b last %0b",
                         got.level_size, got.total_size, got.overflow_error, got.last);
            return;
        end
        want = pending_levels.pop_front();
        if (got.level_size !== want.level_size || got.total_size !== want.total_size ||
            got.overflow_error !== want.overflow_error || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch size/total/err/last: exp %0d %0d %0b %0b got %0d %0d %0b %0b",
                         want.level_size, want.total_size, want.overflow_error, want.last,
                         got.level_size, got.total_size, got.overflow_error, got.last);
        end
    endtask

    // output side: random stalls unless in burst mode, one word per handshake
    initial begin
        int          stall;
        t_level_word got;
        size_if.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            stall = burst_out ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                size_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            size_if.ready <= 1'b1;
            do @(posedge i_clk); while (!size_if.valid);
            got.level_size     = size_if.level_size;
            got.total_size     = size_if.total_size;
            got.overflow_error = size_if.overflow_error;
            got.last           = size_if.last;
            check_level_word(got);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (size_if.valid && size_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_field_extremes();
        send_request(32'hFFFF_FFFF, 4'd1);
        send_request(32'd0, 4'd1);
        send_request(32'd65535, 4'd15);
        send_request(32'd1000000, 4'd8);
    endtask

    task automatic test_small_scaled();
        // scaled values 1, 2 and 3 and an even start
        burst_in  = 1'b1;
        burst_out = 1'b1;
        send_request(32'd5, 4'd1);
        send_request(32'd9, 4'd1);
        send_request(32'd10, 4'd1);
        send_request(32'd14, 4'd1);
        send_request(32'd20, 4'd1);
        send_request(32'd1000, 4'd8);
        burst_in  = 1'b0;
        burst_out = 1'b0;
    endtask

    task automatic test_level_limits();
        send_request(32'd100, 4'd0);
        send_request(32'd50000, 4'd8);
        send_request(32'd50000, 4'd9);
        send_request(32'd3000, 4'd15);
        send_request(32'd7, 4'd0);
        send_request(32'd777, 4'd7);
    endtask

    task automatic test_overflow_stop();
        send_request(32'd0, 4'd8);
        send_request(32'd1, 4'd3);
        send_request(32'd3, 4'd8);
        send_request(32'd40, 4'd15);
    endtask

    task automatic test_random_requests();
        int          roll;
        logic [31:0] count;
        logic [3:0]  levels_req;
        for (int n = 0; n < 80; n++) begin
            if (n % 16 == 0) begin
                burst_in  = ($urandom_range(0, 3) == 0);
                burst_out = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                count      = $urandom;
                levels_req = 4'd1;
            end else if (roll < 12) begin
                count      = $urandom_range(65536, 1 << 20);
                levels_req = 4'($urandom_range(1, 8));
            end else if (roll < 30) begin
                count      = $urandom_range(0, 200);
                levels_req = 4'($urandom_range(0, 15));
            end else begin
                count      = $urandom_range(0, 65535);
                levels_req = 4'($urandom_range(0, 15));
            end
            send_request(count, levels_req);
        end
        burst_in  = 1'b0;
        burst_out = 1'b0;
    endtask

    initial begin
        mismatch_count     = 0;
        burst_in           = 1'b0;
        burst_out          = 1'b0;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.item_count  <= 32'd0;
        req_if.level_count <= 4'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_small_scaled();
        test_level_limits();
        test_overflow_stop();
        test_random_requests();

        req_if.valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[multi_level_prime_size_generator.f]
rtl/mlps_pkg.sv
rtl/mlps_if.sv
rtl/mlps_mul.sv
rtl/mlps_div.sv
rtl/multi_level_prime_size_generator.sv
tb/multi_level_prime_size_generator_tb.sv
